// ----- rtl/mp2a_pkg.sv -----
// ----------------------------------------------------------------------------
// mp2a_pkg
// Shared types and constants of the masked pixel to ARGB8888 converter.
// ----------------------------------------------------------------------------
package mp2a_pkg;

    localparam int PIX_W  = 32;
    localparam int CHAN_W = 8;
    localparam int SHIFT_W = $clog2(PIX_W);
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // register index, taken from paddr[4:2]
    typedef enum logic [2:0] {
        REG_RED_MASK   = 3'd0,
        REG_GREEN_MASK = 3'd1,
        REG_BLUE_MASK  = 3'd2,
        REG_ALPHA_MASK = 3'd3,
        REG_PIXEL_SIZE = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        PSIZE_8  = 2'd0,
        PSIZE_16 = 2'd1,
        PSIZE_24 = 2'd2,
        PSIZE_32 = 2'd3
    } pix_size_t;

    localparam logic [PIX_W-1:0] RED_MASK_RST   = 32'h00FF_0000;
    localparam logic [PIX_W-1:0] GREEN_MASK_RST = 32'h0000_FF00;
    localparam logic [PIX_W-1:0] BLUE_MASK_RST  = 32'h0000_00FF;
    localparam logic [PIX_W-1:0] ALPHA_MASK_RST = 32'hFF00_0000;
    localparam pix_size_t        PIX_SIZE_RST   = PSIZE_32;

    localparam logic [CHAN_W-1:0] CHAN_OPAQUE = 8'hFF;

    // per-stage load enables of the pixel pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } pipe_adv_t;

    function automatic logic [PIX_W-1:0] size_limit(input pix_size_t sel);
        logic [PIX_W-1:0] lim;
        case (sel)
            PSIZE_8:  lim = 32'h0000_00FF;
            PSIZE_16: lim = 32'h0000_FFFF;
            PSIZE_24: lim = 32'h00FF_FFFF;
            default:  lim = 32'hFFFF_FFFF;
        endcase
        return lim;
    endfunction

endpackage

// ----- rtl/mp2a_chan.sv -----
// ----------------------------------------------------------------------------
// mp2a_chan
// One color channel: mask, align to the lowest mask bit, widen to 8 bits.
// ----------------------------------------------------------------------------
module mp2a_chan import mp2a_pkg::*; (
    input  logic              aclk,
    input  pipe_adv_t         adv,
    input  logic [PIX_W-1:0]  pixel,      // already limited to pixel width
    input  logic [PIX_W-1:0]  mask,
    input  logic              opaque_en,  // zero mask gives all ones
    output logic [CHAN_W-1:0] chan
);

    // stage 1: masked field, lowest set bit
    logic [PIX_W-1:0]   masked_reg;
    logic [SHIFT_W-1:0] lo_reg;
    logic               opaque1_reg;
    logic [SHIFT_W-1:0] lo_next;

    always_comb begin
        lo_next = '0;
        for (int i = PIX_W - 1; i >= 0; i--) begin
            if (mask[i]) begin
                lo_next = SHIFT_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.s1) begin
            masked_reg  <= pixel & mask;
            lo_reg      <= lo_next;
            opaque1_reg <= opaque_en && (mask == '0);
        end
    end

    // stage 2: align field and mask
    logic [CHAN_W-1:0] field_reg;
    logic [CHAN_W-1:0] mrun_reg;
    logic              opaque2_reg;
    logic [PIX_W-1:0]  field_sh;
    logic [PIX_W-1:0]  mask_sh;

    assign field_sh = masked_reg >> lo_reg;
    assign mask_sh  = mask >> lo_reg;

    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            field_reg   <= field_sh[CHAN_W-1:0];
            mrun_reg    <= mask_sh[CHAN_W-1:0];
            opaque2_reg <= opaque1_reg;
        end
    end

    // stage 3: run length sets the left shift
    logic [CHAN_W-1:0] chan_reg;
    logic [2:0]        loss;
    logic              gap_seen;

    always_comb begin
        gap_seen = 1'b0;
        loss     = '0;
        for (int i = CHAN_W - 1; i >= 0; i--) begin
            if (!mrun_reg[i]) begin
                gap_seen = 1'b1;
                loss     = 3'(CHAN_W - i);
            end
        end
        if (!gap_seen) begin
            loss = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.s3) begin
            chan_reg <= opaque2_reg ? CHAN_OPAQUE : (field_reg << loss);
        end
    end

    assign chan = chan_reg;

endmodule

// ----- rtl/masked_pixel_to_argb8888.sv -----
// ----------------------------------------------------------------------------
// masked_pixel_to_argb8888
// Bit-mask packed pixel to ARGB8888 converter, three-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one packed pixel per item (tdata = raw pixel, tlast =
//   last pixel of the image). m_ channel gives one ARGB8888 item per input,
//   tdata = {blue, green, red, alpha} with alpha in the low byte, tlast
//   copied through. Four channel masks and the pixel width sit on the APB
//   port at 0x00 red, 0x04 green, 0x08 blue, 0x0C alpha, 0x10 pixel size.
//   Write them only while no item is in flight.
// Timing:
//   One item per cycle sustained while m_tready stays high. The three register
//   stages are: mask and lowest-bit encode, align shift, run-length widen into
//   the output register.
// Reset:
//   aresetn low empties the pipeline and loads the default masks
//   (0x00FF0000, 0x0000FF00, 0x000000FF, 0xFF000000, 32-bit pixels).
// Stall:
//   when m_tready is low, the output holds and the stages behind it fill up;
//   s_tready drops once all three are full. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module masked_pixel_to_argb8888 import mp2a_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [31:0] raw_pixel
    input  logic              s_tlast,   // frame_end

    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [7:0] alpha_out, [15:8] red_out,
                                         // [23:16] green_out, [31:24] blue_out
    output logic              m_tlast,   // frame_end_out

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // ---------------- configuration registers ----------------
    logic [PIX_W-1:0] red_mask_reg;
    logic [PIX_W-1:0] green_mask_reg;
    logic [PIX_W-1:0] blue_mask_reg;
    logic [PIX_W-1:0] alpha_mask_reg;
    pix_size_t        pix_size_reg;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_mask_reg   <= RED_MASK_RST;
            green_mask_reg <= GREEN_MASK_RST;
            blue_mask_reg  <= BLUE_MASK_RST;
            alpha_mask_reg <= ALPHA_MASK_RST;
            pix_size_reg   <= PIX_SIZE_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_RED_MASK:   red_mask_reg   <= pwdata;
                REG_GREEN_MASK: green_mask_reg <= pwdata;
                REG_BLUE_MASK:  blue_mask_reg  <= pwdata;
                REG_ALPHA_MASK: alpha_mask_reg <= pwdata;
                REG_PIXEL_SIZE: pix_size_reg   <= pix_size_t'(pwdata[1:0]);
                default: ;      // unmapped address, write dropped
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_RED_MASK:   prdata = red_mask_reg;
            REG_GREEN_MASK: prdata = green_mask_reg;
            REG_BLUE_MASK:  prdata = blue_mask_reg;
            REG_ALPHA_MASK: prdata = alpha_mask_reg;
            REG_PIXEL_SIZE: prdata = {30'd0, pix_size_reg};
            default:        prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // each stage loads when empty or when the stage ahead moves on
    logic      v1_reg, v2_reg, v3_reg;
    logic      last1_reg, last2_reg, last3_reg;
    pipe_adv_t adv;

    assign adv.s3   = !v3_reg || m_tready;
    assign adv.s2   = !v2_reg || adv.s3;
    assign adv.s1   = !v1_reg || adv.s2;
    assign s_tready = adv.s1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv.s1) v1_reg <= s_tvalid;
            if (adv.s2) v2_reg <= v1_reg;
            if (adv.s3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.s1) last1_reg <= s_tlast;
        if (adv.s2) last2_reg <= last1_reg;
        if (adv.s3) last3_reg <= last2_reg;
    end

    // ---------------- channel datapaths ----------------
    // pixel bits above the configured width read as zero
    logic [PIX_W-1:0]  pix_lim;
    logic [CHAN_W-1:0] alpha_c, red_c, green_c, blue_c;

    assign pix_lim = s_tdata & size_limit(pix_size_reg);

    mp2a_chan u_alpha (
        .aclk      (aclk),
        .adv       (adv),
        .pixel     (pix_lim),
        .mask      (alpha_mask_reg),
        .opaque_en (1'b1),
        .chan      (alpha_c)
    );

    mp2a_chan u_red (
        .aclk      (aclk),
        .adv       (adv),
        .pixel     (pix_lim),
        .mask      (red_mask_reg),
        .opaque_en (1'b0),
        .chan      (red_c)
    );

    mp2a_chan u_green (
        .aclk      (aclk),
        .adv       (adv),
        .pixel     (pix_lim),
        .mask      (green_mask_reg),
        .opaque_en (1'b0),
        .chan      (green_c)
    );

    mp2a_chan u_blue (
        .aclk      (aclk),
        .adv       (adv),
        .pixel     (pix_lim),
        .mask      (blue_mask_reg),
        .opaque_en (1'b0),
        .chan      (blue_c)
    );

    assign m_tvalid = v3_reg;
    assign m_tdata  = {blue_c, green_c, red_c, alpha_c};
    assign m_tlast  = last3_reg;

`ifndef SYNTHESIS
    // an open output never blocks the input
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("s_tready low while m_tready high");

    // an accepted item reaches the output when m_tready stays high after accept
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && m_tready) ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("item missing at output after three cycles");

    // reset empties the pipeline
    a_reset_flush: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");
`endif

endmodule

// ----- bench/masked_pixel_to_argb8888_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_pixel_to_argb8888_tb
// Self-checking bench for the bit-mask pixel to ARGB8888 converter.
// ----------------------------------------------------------------------------
// A short directed table covers reset masks, every pixel width, zero masks,
// the forced-opaque alpha, RGB565, wide and split masks, and mask bits above
// the pixel width. A set of random phases follows. Each phase reprograms all
// five registers (extremes first, then random masks) and streams random
// pixels. Each accepted pixel is converted by a local model (typed table
// rows use their own expectation), queued and compared field by field with
// the next item out. Both stream sides idle at random, with no-gap stretches.
// ----------------------------------------------------------------------------
module masked_pixel_to_argb8888_tb;
    import mp2a_pkg::*;

    localparam int NUM_PHASES  = 12;
    localparam int PHASE_ITEMS = 153;     // ~1850 pixels with the directed rows
    localparam int TAIL_CYCLES = 8;       // pipeline is 3 deep, margin on top
    localparam int CYCLE_LIMIT = 400000;  // far above slowest legal run
    localparam int MAX_REPORTS = 40;
    localparam int NUM_ROWS    = 31;

    // one converted pixel, as predicted or as seen on m_
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } argb_item_t;

    typedef enum logic [0:0] {
        ROW_WRITE = 1'b0,   // register write, done once the pipe is empty
        ROW_PIXEL = 1'b1    // one pixel item
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        reg_idx_t    sel;
        logic [31:0] value;   // pixel, or register value
        logic        last;
        logic        typed;   // 1: expectation below, 0: use the model
        logic [7:0]  alpha;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } dir_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;   // [31:0] raw_pixel
    logic              s_tlast;   // frame_end
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;   // [7:0] alpha, [15:8] red, [23:16] green, [31:24] blue
    logic              m_tlast;   // frame_end_out
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // local copy of the register file, updated on each write
    logic [31:0] red_sel_mask;
    logic [31:0] green_sel_mask;
    logic [31:0] blue_sel_mask;
    logic [31:0] alpha_sel_mask;
    pix_size_t   pix_width;

    argb_item_t  pending_argb[$];   // converted pixels still to come out
    int          mismatches;
    int          results_seen;
    int          pixels_sent;
    int          cycles;
    bit          tx_burst;          // sender: no gaps while set
    bit          rx_burst;          // receiver: no stalls while set
    dir_row_t    dir_rows [NUM_ROWS];

    masked_pixel_to_argb8888 dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Conversion model
    // ------------------------------------------------------------------------

    // shift = lowest set bit, run = ones from there up (max 8), loss = 8 - run
    function automatic logic [7:0] channel_of(input logic [31:0] pix,
                                              input logic [31:0] mask);
        int          lo;
        int          hi;
        int          run;
        logic [31:0] v;
        if (mask == 32'h0)
            return 8'h00;
        lo = 0;
        while (lo < 31 && !mask[lo])
            lo++;
        hi = lo;
        while (hi < 32 && mask[hi])
            hi++;
        run = (hi - lo > 8) ? 8 : hi - lo;
        v = (pix & mask) >> lo;
        v = v << (8 - run);
        return v[7:0];
    endfunction

    function automatic argb_item_t convert_pixel(input logic [31:0] raw,
                                                 input logic last);
        argb_item_t  res;
        logic [31:0] pix;
        case (pix_width)
            PSIZE_8:  pix = raw & 32'h0000_00FF;
            PSIZE_16: pix = raw & 32'h0000_FFFF;
            PSIZE_24: pix = raw & 32'h00FF_FFFF;
            default:  pix = raw;
        endcase
        // no alpha field in the source means fully opaque
        res.alpha = (alpha_sel_mask == 32'h0) ? CHAN_OPAQUE
                                              : channel_of(pix, alpha_sel_mask);
        res.red   = channel_of(pix, red_sel_mask);
        res.green = channel_of(pix, green_sel_mask);
        res.blue  = channel_of(pix, blue_sel_mask);
        res.last  = last;
        return res;
    endfunction

    // mix of the interesting mask shapes
    function automatic logic [31:0] random_mask();
        logic [63:0] run_bits;
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h1 << $urandom_range(0, 31);
            3, 4: begin
                // contiguous run, may exceed 8 or spill past bit 31
                run_bits = ((64'h1 << $urandom_range(1, 12)) - 64'h1)
                           << $urandom_range(0, 31);
                return run_bits[31:0];
            end
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Bus tasks
    // ------------------------------------------------------------------------

    // APB write: setup, then access until pready; shadow follows the write
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RED_MASK:   red_sel_mask   = val;
            REG_GREEN_MASK: green_sel_mask = val;
            REG_BLUE_MASK:  blue_sel_mask  = val;
            REG_ALPHA_MASK: alpha_sel_mask = val;
            REG_PIXEL_SIZE: pix_width      = pix_size_t'(val[1:0]);
            default: ;
        endcase
        // keeps back-to-back writes off the same step
        @(posedge aclk);
    endtask

    // hold the sender until every queued item is out, plus pipeline margin
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_argb.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // one pixel item: random gap, then hold valid until accepted
    task automatic send_pixel(input logic [31:0] pix, input logic last,
                              input logic typed, input argb_item_t typed_exp);
        int gap;
        if ($urandom_range(0, 31) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        // accepted at this edge; config cannot change while items fly
        pending_argb.push_back(typed ? typed_exp : convert_pixel(pix, last));
        pixels_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls on m_tready
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 31) == 0)
                rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 15);
            // only drop ready when there is a stall, never low-then-high in a step
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // compare every accepted item against the oldest expectation
    always @(posedge aclk) begin : argb_check
        argb_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_argb.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected item tdata=%h tlast=%b",
                             $time, m_tdata, m_tlast);
            end else begin
                want = pending_argb.pop_front();
                if (m_tdata[7:0] !== want.alpha || m_tdata[15:8] !== want.red ||
                    m_tdata[23:16] !== want.green || m_tdata[31:24] !== want.blue ||
                    m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t: expected a=%h r=%h g=%h b=%h last=%b, ",
                                  "got a=%h r=%h g=%h b=%h last=%b"},
                                 $time, want.alpha, want.red, want.green,
                                 want.blue, want.last, m_tdata[7:0],
                                 m_tdata[15:8], m_tdata[23:16], m_tdata[31:24],
                                 m_tlast);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d items outstanding",
                     $time, pending_argb.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] cfg_vals [5];
        logic [31:0] pix;
        argb_item_t  typed_exp;
        int          ph;
        int          k;
        int          r;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        mismatches   = 0;
        results_seen = 0;
        pixels_sent  = 0;
        cycles       = 0;
        tx_burst     = 1'b0;
        rx_burst     = 1'b0;
        red_sel_mask   = RED_MASK_RST;
        green_sel_mask = GREEN_MASK_RST;
        blue_sel_mask  = BLUE_MASK_RST;
        alpha_sel_mask = ALPHA_MASK_RST;
        pix_width      = PIX_SIZE_RST;

        // kind, reg, value, last, typed, alpha, red, green, blue
        dir_rows = '{
            // reset masks, 32-bit pixels: fields read straight off the bytes
            '{ROW_PIXEL, REG_RED_MASK,   32'h0000_0000, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00},
            '{ROW_PIXEL, REG_RED_MASK,   32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
            '{ROW_PIXEL, REG_RED_MASK,   32'h1122_3344, 1'b0, 1'b1, 8'h11, 8'h22, 8'h33, 8'h44},
            // 8-bit pixel: only blue survives
            '{ROW_WRITE, REG_PIXEL_SIZE, 32'(PSIZE_8),  1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
            '{ROW_PIXEL, REG_RED_MASK,   32'hFFFF_FFFF, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 8'hFF},
            '{ROW_WRITE, REG_PIXEL_SIZE, 32'(PSIZE_16), 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
            '{ROW_PIXEL, REG_RED_MASK,   32'hAABB_CCDD, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
            '{ROW_WRITE, REG_PIXEL_SIZE, 32'(PSIZE_24), 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
            '{ROW_PIXEL, REG_RED_MASK,   32'hAABB_CCDD, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
            // zero alpha mask forces opaque
            '{ROW_WRITE, REG_ALPHA_MASK, 32'h0000_0000, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
            '{ROW_PIXEL, REG_RED_MASK,   32'h0000_0000, 1'b0, 1'b1, 8'hFF, 8'h00, 8'h00, 8'h00},
            // zero red mask gives a zero channel
            '{ROW_WRITE, REG_RED_MASK,   32'h0000_0000, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
            '{ROW_PIXEL, REG_RED_MASK,   32'hFFFF_FFFF, 1'b0, 1'b1, 8'hFF, 8'h00, 8'hFF, 8'hFF},
            // RGB565, upper half of the word ignored
            '{ROW_WRITE, REG_PIXEL_SIZE, 32'(PSIZE_16), 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
            '{ROW_WRITE, REG_RED_MASK,   32'h0000_F800, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
            '{ROW_WRITE, REG_GREEN_MASK, 32'h0000_07E0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
            '{ROW_WRITE, REG_BLUE_MASK,  32'h0000_001F, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
            '{ROW_PIXEL, REG_RED_MASK,   32'h0000_FFFF, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
            '{ROW_PIXEL, REG_RED_MASK,   32'h0000_8410, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
            '{ROW_PIXEL, REG_RED_MASK,   32'hFFFF_0000, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
            // wide run, split mask, full-word mask, lone top bit
            '{ROW_WRITE, REG_PIXEL_SIZE, 32'(PSIZE_32), 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
            '{ROW_WRITE, REG_RED_MASK,   32'h0000_FFF0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
            '{ROW_WRITE, REG_GREEN_MASK, 32'h00F0_000F, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
            '{ROW_WRITE, REG_BLUE_MASK,  32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
            '{ROW_WRITE, REG_ALPHA_MASK, 32'h8000_0000, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
            '{ROW_PIXEL, REG_RED_MASK,   32'h00A0_ABC5, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
            '{ROW_PIXEL, REG_RED_MASK,   32'h8000_0000, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
            '{ROW_PIXEL, REG_RED_MASK,   32'h5A5A_A5A5, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
            // masks reaching above an 8-bit pixel see zeros
            '{ROW_WRITE, REG_PIXEL_SIZE, 32'(PSIZE_8),  1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
            '{ROW_PIXEL, REG_RED_MASK,   32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
            '{ROW_PIXEL, REG_RED_MASK,   32'h0000_005A, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00}
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (r = 0; r < NUM_ROWS; r++) begin
            if (dir_rows[r].kind == ROW_WRITE) begin
                drain();
                write_reg(dir_rows[r].sel, dir_rows[r].value);
            end else begin
                typed_exp = '{alpha: dir_rows[r].alpha, red: dir_rows[r].red,
                              green: dir_rows[r].green, blue: dir_rows[r].blue,
                              last: dir_rows[r].last};
                send_pixel(dir_rows[r].value, dir_rows[r].last,
                           dir_rows[r].typed, typed_exp);
            end
        end

        // random phases, each with a fresh register setting
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            case (ph)
                0: cfg_vals = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 32'(PSIZE_32)};
                1: cfg_vals = '{32'h0, 32'h0, 32'h0, 32'h0, 32'(PSIZE_8)};
                2: cfg_vals = '{RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST,
                                ALPHA_MASK_RST, 32'(PSIZE_32)};
                default: cfg_vals = '{random_mask(), random_mask(), random_mask(),
                                      random_mask(), $urandom};
            endcase
            for (k = 0; k < 5; k++)
                write_reg(reg_idx_t'(k), cfg_vals[k]);

            for (k = 0; k < PHASE_ITEMS; k++) begin
                // sender hold-off until the pipe is empty, mid-phase
                if (k == PHASE_ITEMS / 2 && ph % 3 == 1)
                    drain();
                case ($urandom_range(0, 15))
                    0:       pix = 32'h0000_0000;
                    1:       pix = 32'hFFFF_FFFF;
                    default: pix = $urandom;
                endcase
                send_pixel(pix, ($urandom_range(0, 15) == 0), 1'b0, '0);
            end
        end

        drain();
        $display("Converted %0d pixels under %0d register settings plus the directed table",
                 pixels_sent, NUM_PHASES);
        $display("%0d items checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
